// File: rtl/gbfw_pkg.sv
// ----------------------------------------------------------------------------
// gbfw_pkg: shared types for the breadth-first graph walker
// Item and result structs, command codes, status codes and walker states.
// ----------------------------------------------------------------------------
package gbfw_pkg;

  localparam int unsigned MaxVerticesDef = 16;
  localparam int unsigned MaxEdgesDef    = 64;
  localparam int unsigned VtxW           = 4;
  localparam int unsigned CountW         = 5;

  typedef enum logic [1:0] {
    KindAddEdge = 2'd0,
    KindStart   = 2'd1,
    KindClear   = 2'd2,
    KindNone    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusDropped  = 2'd1,
    StatusBadStart = 2'd2,
    StatusRsvd     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]      kind;
    logic [VtxW-1:0] from_vertex;
    logic [VtxW-1:0] to_vertex;
  } item_t;

  typedef struct packed {
    logic [VtxW-1:0] vertex;
    logic            last;
    logic [1:0]      status;
  } result_t;

  typedef enum logic [2:0] {
    StIdle,
    StPop,
    StHead,
    StEdge,
    StNext,
    StDone
  } walk_state_e;

endpackage

// File: rtl/graph_breadth_first_walk.sv
// ----------------------------------------------------------------------------
// graph_breadth_first_walk: BFS over an adjacency-list graph
// Front queue of commands feeding a graph store and walk engine.
// ----------------------------------------------------------------------------
// channel   | direction | handshake        | payload
// command   | in        | start / busy     | item_i
// result    | out       | result_valid_o   | result_o
// config    | in        | cfg_we_i         | cfg_data_i (vertex_count)
// A transferred command is registered in the front queue before the engine sees it.
// Add edge, clear and rejected commands execute in the engine's idle state; a walk
// steps through pop and head per vertex dequeued, edge and next per edge, then done.
// The front queue holds two commands, so busy rises only when both wait.
// Reset empties the graph; results cannot be stalled by the receiver.
module graph_breadth_first_walk #(
  parameter int unsigned MaxVertices = gbfw_pkg::MaxVerticesDef,
  parameter int unsigned MaxEdges    = gbfw_pkg::MaxEdgesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  gbfw_pkg::item_t   item_i,
  output logic              result_valid_o,
  output gbfw_pkg::result_t result_o,
  input  logic              cfg_we_i,
  input  logic [4:0]        cfg_data_i
);

  logic [4:0]      count_q;
  logic            pop, avail;
  gbfw_pkg::item_t head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= 5'd16;
    else if (cfg_we_i) count_q <= cfg_data_i;
  end

  gbfw_front u_front (
    .clk_i, .rst_ni, .start, .busy, .item_i,
    .pop_i(pop), .avail_o(avail), .head_o(head)
  );

  gbfw_back #(.MaxVertices(MaxVertices), .MaxEdges(MaxEdges)) u_back (
    .clk_i, .rst_ni, .count_i(count_q), .avail_i(avail), .cmd_i(head),
    .pop_o(pop), .res_valid_o(result_valid_o), .res_o(result_o)
  );

endmodule

// File: rtl/gbfw_front.sv
// ----------------------------------------------------------------------------
// gbfw_front: command front end
// Accepts items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module gbfw_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  gbfw_pkg::item_t item_i,
  input  logic            pop_i,
  output logic            avail_o,
  output gbfw_pkg::item_t head_o
);

  gbfw_pkg::item_t q_mem [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;
  logic            push;

  assign busy    = (cnt_q == 2'd2);
  assign push    = start && !busy &&
                   (item_i.kind != gbfw_pkg::KindNone);
  assign avail_o = (cnt_q != 2'd0);
  assign head_o  = q_mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

`ifndef SYNTH
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> avail_o) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !push) else $error("push into full queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count overflow");
`endif

endmodule

// File: rtl/gbfw_back.sv
// ----------------------------------------------------------------------------
// gbfw_back: graph store and walk engine
// Executes queued commands: edge appends, clears and breadth-first walks.
// ----------------------------------------------------------------------------
module gbfw_back #(
  parameter int unsigned MaxVertices = gbfw_pkg::MaxVerticesDef,
  parameter int unsigned MaxEdges    = gbfw_pkg::MaxEdgesDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [4:0]             count_i,
  input  logic                   avail_i,
  input  gbfw_pkg::item_t        cmd_i,
  output logic                   pop_o,
  output logic                   res_valid_o,
  output gbfw_pkg::result_t      res_o
);

  localparam int unsigned VIdxW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned EIdxW = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
  localparam int unsigned ECntW = $clog2(MaxEdges + 1);
  localparam int unsigned VLim  = (MaxVertices < 16) ? MaxVertices : 16;

  // edge store
  logic [gbfw_pkg::VtxW-1:0] tgt_mem  [MaxEdges];
  logic [EIdxW-1:0]          link_mem [MaxEdges];
  logic                      link_nul [MaxEdges];
  logic [EIdxW-1:0]          head_q   [MaxVertices];
  logic [EIdxW-1:0]          tail_q   [MaxVertices];
  logic [MaxVertices-1:0]    has_q;
  logic [ECntW-1:0]          used_q;
  logic [15:0]               vis_q;
  logic [3:0]                fifo_q   [16];
  logic [4:0]                rp_q, wp_q;
  logic [4:0]                nout_q;

  gbfw_pkg::walk_state_e st_q, st_d;
  logic [EIdxW-1:0] e_q;
  logic [3:0]       w_q;
  logic             wnul_q;
  logic [EIdxW-1:0] wlink_q;
  logic [4:0]       cnt;
  logic [3:0]       u;
  logic [3:0]       pend_v_q;

  assign cnt = (count_i > 5'(VLim)) ? 5'(VLim) : count_i;
  assign u   = fifo_q[rp_q[3:0]];

  // command execution in idle
  logic is_add, is_start, is_clear, add_ok, start_ok;
  logic [VIdxW-1:0] fv;
  assign fv       = VIdxW'(cmd_i.from_vertex);
  assign is_add   = avail_i && st_q == gbfw_pkg::StIdle &&
                    cmd_i.kind == gbfw_pkg::KindAddEdge;
  assign is_start = avail_i && st_q == gbfw_pkg::StIdle &&
                    cmd_i.kind == gbfw_pkg::KindStart;
  assign is_clear = avail_i && st_q == gbfw_pkg::StIdle &&
                    cmd_i.kind == gbfw_pkg::KindClear;
  assign add_ok   = {1'b0, cmd_i.from_vertex} < cnt &&
                    {1'b0, cmd_i.to_vertex} < cnt && used_q < ECntW'(MaxEdges);
  assign start_ok = {1'b0, cmd_i.from_vertex} < cnt;
  assign pop_o    = avail_i && st_q == gbfw_pkg::StIdle;

  logic push_ok;
  assign push_ok = st_q == gbfw_pkg::StEdge && {1'b0, w_q} < cnt &&
                   !vis_q[w_q] && nout_q < 5'd16;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      gbfw_pkg::StIdle: if (is_start && start_ok) st_d = gbfw_pkg::StPop;
      gbfw_pkg::StPop:  st_d = (rp_q == wp_q) ? gbfw_pkg::StDone
                                              : gbfw_pkg::StHead;
      gbfw_pkg::StHead: st_d = ({1'b0, u} < 5'(VLim) && has_q[VIdxW'(u)])
                               ? gbfw_pkg::StEdge : gbfw_pkg::StPop;
      gbfw_pkg::StEdge: st_d = gbfw_pkg::StNext;
      gbfw_pkg::StNext: st_d = wnul_q ? gbfw_pkg::StPop : gbfw_pkg::StEdge;
      gbfw_pkg::StDone: st_d = gbfw_pkg::StIdle;
      default:          st_d = gbfw_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (is_add && add_ok) begin
      tgt_mem[EIdxW'(used_q)]  <= cmd_i.to_vertex;
      link_nul[EIdxW'(used_q)] <= 1'b1;
      if (has_q[fv]) begin
        link_mem[tail_q[fv]] <= EIdxW'(used_q);
        link_nul[tail_q[fv]] <= 1'b0;
      end else begin
        head_q[fv] <= EIdxW'(used_q);
      end
      tail_q[fv] <= EIdxW'(used_q);
    end
    if (is_start) fifo_q[0] <= cmd_i.from_vertex;
    if (push_ok) fifo_q[wp_q[3:0]] <= w_q;
    if (st_q == gbfw_pkg::StHead) e_q <= head_q[VIdxW'(u)];
    if (st_q == gbfw_pkg::StNext) e_q <= wlink_q;
    if (st_q == gbfw_pkg::StHead || st_q == gbfw_pkg::StNext) begin
      w_q <= tgt_mem[(st_q == gbfw_pkg::StHead) ? head_q[VIdxW'(u)] : wlink_q];
    end
    if (st_q == gbfw_pkg::StEdge) begin
      wnul_q  <= link_nul[e_q];
      wlink_q <= link_mem[e_q];
    end
    if (st_q == gbfw_pkg::StHead) begin
      wnul_q <= 1'b0;
    end
  end

  // result staging: hold one vertex back so the final one carries last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= gbfw_pkg::StIdle;
      has_q       <= '0;
      used_q      <= '0;
      vis_q       <= '0;
      rp_q        <= '0;
      wp_q        <= '0;
      nout_q      <= '0;
      pend_v_q    <= '0;
      res_valid_o <= 1'b0;
      res_o       <= '0;
    end else begin
      st_q        <= st_d;
      res_valid_o <= 1'b0;
      if (is_clear) begin
        has_q  <= '0;
        used_q <= '0;
        vis_q  <= '0;
      end
      if (is_add) begin
        if (add_ok) begin
          has_q[fv] <= 1'b1;
          used_q    <= used_q + ECntW'(1);
        end else begin
          res_valid_o <= 1'b1;
          res_o <= '{vertex: '0, last: 1'b1, status: gbfw_pkg::StatusDropped};
        end
      end
      if (is_start) begin
        if (start_ok) begin
          vis_q    <= 16'd1 << cmd_i.from_vertex;
          rp_q     <= 5'd0;
          wp_q     <= 5'd1;
          nout_q   <= 5'd1;
          pend_v_q <= cmd_i.from_vertex;
        end else begin
          res_valid_o <= 1'b1;
          res_o <= '{vertex: '0, last: 1'b1, status: gbfw_pkg::StatusBadStart};
        end
      end
      if (st_q == gbfw_pkg::StHead) rp_q <= rp_q + 5'd1;
      if (push_ok) begin
        vis_q[w_q]  <= 1'b1;
        wp_q        <= wp_q + 5'd1;
        nout_q      <= nout_q + 5'd1;
        pend_v_q    <= w_q;
        res_valid_o <= 1'b1;
        res_o <= '{vertex: pend_v_q, last: 1'b0, status: gbfw_pkg::StatusOk};
      end
      if (st_q == gbfw_pkg::StDone) begin
        res_valid_o <= 1'b1;
        res_o <= '{vertex: pend_v_q, last: 1'b1, status: gbfw_pkg::StatusOk};
      end
    end
  end

`ifndef SYNTH
  a_wp_ge_rp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != gbfw_pkg::StIdle |-> wp_q >= rp_q) else $error("walk queue underrun");
  a_nout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nout_q <= 5'd16) else $error("too many results");
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == gbfw_pkg::StDone |=> res_valid_o && res_o.last)
    else $error("walk ended without last");
`endif

endmodule

// File: tb/graph_breadth_first_walk_tb.sv
// ----------------------------------------------------------------------------
// graph_breadth_first_walk_tb: self-checking bench for the BFS graph walker
// Drives add-edge, walk and clear commands with random start gaps, changes
// the vertex count between phases, and checks every result transfer against
// a behavioral BFS predictor kept in the bench.
// ----------------------------------------------------------------------------
module graph_breadth_first_walk_tb;

  localparam int NumVtx   = 16;
  localparam int NumEdges = 64;
  localparam int NullLink = NumEdges;
  localparam int CycLimit = 1200000;
  localparam int ExpDepth = 8192;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  gbfw_pkg::item_t   item_i = '0;
  logic              result_valid_o;
  gbfw_pkg::result_t result_o;
  logic              cfg_we_i = 1'b0;
  logic [4:0]        cfg_data_i = 5'd16;

  graph_breadth_first_walk i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [4:0]        vtx_count;
  logic [3:0]        edge_tgt [NumEdges];
  int                edge_nxt [NumEdges];
  int                head_edge [NumVtx];
  int                tail_edge [NumVtx];
  int                n_edges;
  gbfw_pkg::result_t exp_mem [ExpDepth];
  int                exp_rd = 0;
  int                exp_wr = 0;
  bit                failed = 1'b0;
  int                cycles = 0;
  bit                long_run_quiet = 1'b0;

  function automatic void graph_clear();
    for (int v = 0; v < NumVtx; v++) head_edge[v] = NullLink;
    n_edges = 0;
  endfunction

  function automatic void push_result(logic [3:0] v, logic l, gbfw_pkg::status_e s);
    gbfw_pkg::result_t r;
    r.vertex = v; r.last = l; r.status = s;
    exp_mem[exp_wr] = r;
    exp_wr++;
  endfunction

  function automatic void predict_walk(gbfw_pkg::item_t it);
    int   cnt;
    bit   seen [NumVtx];
    int   bfs_q [NumVtx];
    int   bq_rd, bq_wr;
    int   u, e, w, n;
    cnt = (vtx_count > NumVtx) ? NumVtx : vtx_count;
    case (gbfw_pkg::kind_e'(it.kind))
      gbfw_pkg::KindClear: graph_clear();
      gbfw_pkg::KindAddEdge: begin
        if (it.from_vertex >= cnt || it.to_vertex >= cnt || n_edges >= NumEdges) begin
          push_result(4'd0, 1'b1, gbfw_pkg::StatusDropped);
        end else begin
          edge_tgt[n_edges] = it.to_vertex;
          edge_nxt[n_edges] = NullLink;
          if (head_edge[it.from_vertex] == NullLink) head_edge[it.from_vertex] = n_edges;
          else edge_nxt[tail_edge[it.from_vertex]] = n_edges;
          tail_edge[it.from_vertex] = n_edges;
          n_edges++;
        end
      end
      gbfw_pkg::KindStart: begin
        if (it.from_vertex >= cnt) begin
          push_result(4'd0, 1'b1, gbfw_pkg::StatusBadStart);
        end else begin
          for (int i = 0; i < NumVtx; i++) seen[i] = 1'b0;
          seen[it.from_vertex] = 1'b1;
          bq_rd = 0;
          bq_wr = 0;
          bfs_q[bq_wr] = it.from_vertex;
          bq_wr++;
          push_result(it.from_vertex, 1'b0, gbfw_pkg::StatusOk);
          n = 1;
          while (bq_rd < bq_wr) begin
            u = bfs_q[bq_rd];
            bq_rd++;
            e = head_edge[u];
            while (e < NullLink) begin
              w = edge_tgt[e];
              if (w < cnt && !seen[w] && n < 16) begin
                seen[w] = 1'b1;
                bfs_q[bq_wr] = w;
                bq_wr++;
                push_result(w[3:0], 1'b0, gbfw_pkg::StatusOk);
                n++;
              end
              e = edge_nxt[e];
            end
          end
          exp_mem[exp_wr-1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && result_valid_o) begin
      if (exp_wr == exp_rd) begin
        $display("%0t: unexpected result, actual %p", $time, result_o);
        failed = 1'b1;
      end else begin
        gbfw_pkg::result_t x;
        x = exp_mem[exp_rd];
        exp_rd = exp_rd + 1;
        if (x.vertex !== result_o.vertex || x.last !== result_o.last ||
            x.status !== result_o.status) begin
          $display("%0t: mismatch, expected %p actual %p", $time, x, result_o);
          failed = 1'b1;
        end
      end
    end
    if (cycles > CycLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_cmd(logic [1:0] k, logic [3:0] f, logic [3:0] t);
    gbfw_pkg::item_t it;
    it.kind = k; it.from_vertex = f; it.to_vertex = t;
    if (!long_run_quiet) begin
      while ($urandom_range(99) < 31) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_walk(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_count(logic [4:0] c);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= c;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    vtx_count = c;
    @(posedge clk_i);
  endtask

  // directed rows: kind, from, to, check-at-a-glance flag, expected result
  typedef struct {
    logic [1:0]        k;
    logic [3:0]        f;
    logic [3:0]        t;
    bit                typed;
    gbfw_pkg::result_t r;
  } row_t;

  row_t dir_rows [] = '{
    '{gbfw_pkg::KindStart,   4'd0,  4'd0,  1, '{4'd0, 1'b1, gbfw_pkg::StatusOk}},
    '{gbfw_pkg::KindStart,   4'd15, 4'd0,  1, '{4'd15, 1'b1, gbfw_pkg::StatusOk}},
    '{gbfw_pkg::KindNone,    4'd15, 4'd15, 0, '{4'd0, 1'b0, gbfw_pkg::StatusOk}},
    '{gbfw_pkg::KindAddEdge, 4'd0,  4'd15, 0, '{4'd0, 1'b0, gbfw_pkg::StatusOk}},
    '{gbfw_pkg::KindAddEdge, 4'd0,  4'd1,  0, '{4'd0, 1'b0, gbfw_pkg::StatusOk}},
    '{gbfw_pkg::KindAddEdge, 4'd1,  4'd2,  0, '{4'd0, 1'b0, gbfw_pkg::StatusOk}},
    '{gbfw_pkg::KindAddEdge, 4'd15, 4'd0,  0, '{4'd0, 1'b0, gbfw_pkg::StatusOk}},
    '{gbfw_pkg::KindAddEdge, 4'd2,  4'd0,  0, '{4'd0, 1'b0, gbfw_pkg::StatusOk}},
    '{gbfw_pkg::KindStart,   4'd0,  4'd0,  0, '{4'd0, 1'b0, gbfw_pkg::StatusOk}},
    '{gbfw_pkg::KindStart,   4'd2,  4'd9,  0, '{4'd0, 1'b0, gbfw_pkg::StatusOk}},
    '{gbfw_pkg::KindClear,   4'd0,  4'd0,  0, '{4'd0, 1'b0, gbfw_pkg::StatusOk}},
    '{gbfw_pkg::KindStart,   4'd0,  4'd0,  1, '{4'd0, 1'b1, gbfw_pkg::StatusOk}}
  };

  row_t small_rows [] = '{
    '{gbfw_pkg::KindAddEdge, 4'd4,  4'd1,  1, '{4'd0, 1'b1, gbfw_pkg::StatusDropped}},
    '{gbfw_pkg::KindAddEdge, 4'd1,  4'd4,  1, '{4'd0, 1'b1, gbfw_pkg::StatusDropped}},
    '{gbfw_pkg::KindStart,   4'd4,  4'd0,  1, '{4'd0, 1'b1, gbfw_pkg::StatusBadStart}},
    '{gbfw_pkg::KindStart,   4'd3,  4'd0,  0, '{4'd0, 1'b0, gbfw_pkg::StatusOk}},
    '{gbfw_pkg::KindStart,   4'd0,  4'd0,  0, '{4'd0, 1'b0, gbfw_pkg::StatusOk}}
  };

  task automatic run_rows(row_t rows []);
    foreach (rows[i]) begin
      send_cmd(rows[i].k, rows[i].f, rows[i].t);
      if (rows[i].typed) begin
        if (exp_wr == exp_rd || exp_mem[exp_wr-1] !== rows[i].r) begin
          $display("%0t: table row %0d predictor disagrees, expected %p", $time, i,
                   rows[i].r);
          failed = 1'b1;
        end
      end
    end
  endtask

  task automatic random_phase(int n, int cnt);
    int k, hi;
    hi = (cnt == 0) ? 15 : ((cnt > 16) ? 15 : cnt - 1);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 60) send_cmd(gbfw_pkg::KindAddEdge,
          ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(hi)),
          ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(hi)));
      else if (k < 90) send_cmd(gbfw_pkg::KindStart,
          ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(hi)), 4'($urandom));
      else if (k < 95) send_cmd(gbfw_pkg::KindClear, 4'($urandom), 4'($urandom));
      else send_cmd(gbfw_pkg::KindNone, 4'($urandom), 4'($urandom));
    end
  endtask

  initial begin
    vtx_count = 5'd16;
    graph_clear();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_rows(dir_rows);
    set_count(5'd4);
    send_cmd(gbfw_pkg::KindClear, 4'd0, 4'd0);
    send_cmd(gbfw_pkg::KindAddEdge, 4'd0, 4'd3);
    send_cmd(gbfw_pkg::KindAddEdge, 4'd3, 4'd3);
    run_rows(small_rows);
    set_count(5'd0);
    send_cmd(gbfw_pkg::KindAddEdge, 4'd0, 4'd0);
    send_cmd(gbfw_pkg::KindStart, 4'd0, 4'd0);
    set_count(5'd31);
    random_phase(60, 16);
    // edge store overflow
    for (int i = 0; i < 70; i++) begin
      send_cmd(gbfw_pkg::KindAddEdge, 4'($urandom), 4'($urandom));
    end
    send_cmd(gbfw_pkg::KindStart, 4'($urandom), 4'd0);
    drain();
    long_run_quiet = 1'b1;
    send_cmd(gbfw_pkg::KindClear, 4'd0, 4'd0);
    random_phase(60, 16);
    long_run_quiet = 1'b0;
    set_count(5'd1);
    random_phase(20, 1);
    set_count(5'd9);
    random_phase(60, 9);
    // stale edges after shrink
    set_count(5'd16);
    random_phase(30, 16);
    set_count(5'd6);
    random_phase(30, 6);
    set_count(5'd16);
    random_phase(20, 16);
    drain();
    if (!failed && exp_wr == exp_rd) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/gbfw_pkg.sv
rtl/gbfw_front.sv
rtl/gbfw_back.sv
rtl/graph_breadth_first_walk.sv
tb/graph_breadth_first_walk_tb.sv
